// ----- hw/rtl/rv32ie_pkg.sv -----
`timescale 1ns / 1ps

package rv32ie_pkg;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_ALUI   = 7'h13;
    localparam logic [6:0] OPC_ALUR   = 7'h33;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SW  = 3'd2;

    typedef enum logic [3:0] {
        CLS_LUI,
        CLS_AUIPC,
        CLS_JAL,
        CLS_JALR,
        CLS_BRANCH,
        CLS_LOAD,
        CLS_STORE,
        CLS_ALUI,
        CLS_ALUR,
        CLS_PRELOAD,
        CLS_ILLEGAL
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  funct3;
        logic        alt;
        logic        wr;
        logic [31:0] imm;
        logic [11:0] preload_address;
        logic [31:0] preload_data;
    } item_t;

    typedef struct packed {
        logic [31:0] executed_pc;
        logic [31:0] next_pc;
        logic        write_enable;
        logic [4:0]  write_register;
        logic [31:0] write_value;
        logic        memory_fault;
        logic        illegal_instruction;
    } result_t;

endpackage

// ----- hw/rtl/rv32ie_front.sv -----
`timescale 1ns / 1ps

module rv32ie_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [31:0]         s_instruction,
    input  logic [11:0]         s_preload_address,
    input  logic [31:0]         s_preload_data,
    input  logic                clearing,
    input  logic                q_full,
    output logic                push,
    output rv32ie_pkg::item_t   item
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic        writes;

    assign s_ready = !q_full && !clearing;
    assign push    = s_valid && s_ready;

    assign opc   = s_instruction[6:0];
    assign f3    = s_instruction[14:12];
    assign f7    = s_instruction[31:25];
    assign imm_i = {{20{s_instruction[31]}}, s_instruction[31:20]};
    assign imm_s = {{20{s_instruction[31]}}, s_instruction[31:25], s_instruction[11:7]};
    assign imm_b = {{19{s_instruction[31]}}, s_instruction[31], s_instruction[7],
                    s_instruction[30:25], s_instruction[11:8], 1'b0};
    assign imm_u = {s_instruction[31:12], 12'd0};
    assign imm_j = {{11{s_instruction[31]}}, s_instruction[31], s_instruction[19:12],
                    s_instruction[20], s_instruction[30:21], 1'b0};

    always_comb begin
        item                 = '0;
        item.cls             = rv32ie_pkg::CLS_ILLEGAL;
        item.rd              = s_instruction[11:7];
        item.rs1             = s_instruction[19:15];
        item.rs2             = s_instruction[24:20];
        item.funct3          = f3;
        item.preload_address = s_preload_address;
        item.preload_data    = s_preload_data;
        writes               = 1'b0;
        if (s_operation) begin
            item.cls = rv32ie_pkg::CLS_PRELOAD;
        end else begin
            case (opc)
                rv32ie_pkg::OPC_LUI: begin
                    item.cls = rv32ie_pkg::CLS_LUI;
                    item.imm = imm_u;
                    writes   = 1'b1;
                end
                rv32ie_pkg::OPC_AUIPC: begin
                    item.cls = rv32ie_pkg::CLS_AUIPC;
                    item.imm = imm_u;
                    writes   = 1'b1;
                end
                rv32ie_pkg::OPC_JAL: begin
                    item.cls = rv32ie_pkg::CLS_JAL;
                    item.imm = imm_j;
                    writes   = 1'b1;
                end
                rv32ie_pkg::OPC_JALR: begin
                    if (f3 == rv32ie_pkg::F3_ADD) begin
                        item.cls = rv32ie_pkg::CLS_JALR;
                        item.imm = imm_i;
                        writes   = 1'b1;
                    end
                end
                rv32ie_pkg::OPC_BRANCH: begin
                    if (f3 != rv32ie_pkg::F3_SLT && f3 != rv32ie_pkg::F3_SLTU) begin
                        item.cls = rv32ie_pkg::CLS_BRANCH;
                        item.imm = imm_b;
                    end
                end
                rv32ie_pkg::OPC_LOAD: begin
                    if (f3 == rv32ie_pkg::F3_LB || f3 == rv32ie_pkg::F3_LH ||
                        f3 == rv32ie_pkg::F3_LW || f3 == rv32ie_pkg::F3_LBU ||
                        f3 == rv32ie_pkg::F3_LHU) begin
                        item.cls = rv32ie_pkg::CLS_LOAD;
                        item.imm = imm_i;
                        writes   = 1'b1;
                    end
                end
                rv32ie_pkg::OPC_STORE: begin
                    if (f3 <= rv32ie_pkg::F3_SW) begin
                        item.cls = rv32ie_pkg::CLS_STORE;
                        item.imm = imm_s;
                    end
                end
                rv32ie_pkg::OPC_ALUI: begin
                    if (!(f3 == rv32ie_pkg::F3_SLL && f7 != rv32ie_pkg::F7_ZERO) &&
                        !(f3 == rv32ie_pkg::F3_SR && f7 != rv32ie_pkg::F7_ZERO &&
                          f7 != rv32ie_pkg::F7_ALT)) begin
                        item.cls = rv32ie_pkg::CLS_ALUI;
                        item.imm = imm_i;
                        item.alt = (f3 == rv32ie_pkg::F3_SR) && (f7 == rv32ie_pkg::F7_ALT);
                        writes   = 1'b1;
                    end
                end
                rv32ie_pkg::OPC_ALUR: begin
                    if (f7 == rv32ie_pkg::F7_ZERO ||
                        (f7 == rv32ie_pkg::F7_ALT &&
                         (f3 == rv32ie_pkg::F3_ADD || f3 == rv32ie_pkg::F3_SR))) begin
                        item.cls = rv32ie_pkg::CLS_ALUR;
                        item.alt = (f7 == rv32ie_pkg::F7_ALT);
                        writes   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        item.wr = writes && (item.rd != 5'd0);
    end

endmodule

// ----- hw/rtl/rv32ie_queue.sv -----
`timescale 1ns / 1ps

module rv32ie_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rv32ie_pkg::item_t   push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output rv32ie_pkg::item_t   head_item
);

    rv32ie_pkg::item_t entry_reg [2];
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/rv32ie_back.sv -----
`timescale 1ns / 1ps

module rv32ie_back #(
    parameter int MEM_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr,
    input  logic [11:0]           cfg_pc,
    input  logic                  q_valid,
    input  rv32ie_pkg::item_t     q_item,
    output logic                  q_pop,
    output logic                  clearing,
    input  logic                  m_ready,
    output logic                  m_valid,
    output rv32ie_pkg::result_t   m_result
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = AW - 2;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_READ  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_MEM   = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [RW-1:0]       clr_cnt_reg;
    logic [31:0]         pc_reg;

    logic [31:0]         rf_mem [32];
    logic [31:0]         rf_valid_reg;
    logic [31:0]         rs1_data_reg;
    logic [31:0]         rs2_data_reg;
    logic                rs1_vld_reg;
    logic                rs2_vld_reg;
    logic                rf_we;
    logic [31:0]         rf_wdata;

    logic [7:0]          bank_q [4];
    logic [31:0]         ld_pc_reg;
    logic                ld_fault_reg;
    logic [1:0]          ld_a0_reg;

    logic                m_valid_reg;
    rv32ie_pkg::result_t res_reg;
    rv32ie_pkg::result_t res_next;

    rv32ie_pkg::item_t   it;
    logic                st_clear;
    logic                st_exec;
    logic                st_mem;
    logic                is_load;
    logic                out_free;
    logic                finish;
    logic [31:0]         a;
    logic [31:0]         b;
    logic [31:0]         op2;
    logic [4:0]          shamt;
    logic [31:0]         alu_val;
    logic                taken;
    logic [31:0]         pc_plus4;
    logic [31:0]         pc_imm;
    logic [31:0]         ea;
    logic [31:0]         mem_addr;
    logic [2:0]          nbytes;
    logic [31:0]         lim;
    logic                in_range;
    logic [31:0]         st_data;
    logic                mem_we;
    logic [31:0]         npc;
    logic [31:0]         val;
    logic                fault;
    logic [7:0]          lb0;
    logic [7:0]          lb1;
    logic [7:0]          lb2;
    logic [7:0]          lb3;
    logic [31:0]         ld_val;

    assign it       = q_item;
    assign st_clear = (state_reg == S_CLEAR);
    assign st_exec  = (state_reg == S_EXEC);
    assign st_mem   = (state_reg == S_MEM);
    assign clearing = st_clear;
    assign is_load  = (it.cls == rv32ie_pkg::CLS_LOAD);
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (st_exec && !is_load && out_free) || (st_mem && out_free);
    assign q_pop    = finish;
    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

    // Registers never written read as zero, which also keeps x0 at zero.
    assign a     = rs1_vld_reg ? rs1_data_reg : 32'd0;
    assign b     = rs2_vld_reg ? rs2_data_reg : 32'd0;
    assign op2   = (it.cls == rv32ie_pkg::CLS_ALUR) ? b : it.imm;
    assign shamt = op2[4:0];

    always_comb begin
        case (it.funct3)
            rv32ie_pkg::F3_ADD:  alu_val = it.alt ? (a - op2) : (a + op2);
            rv32ie_pkg::F3_SLL:  alu_val = a << shamt;
            rv32ie_pkg::F3_SLT:  alu_val = {31'd0, $signed(a) < $signed(op2)};
            rv32ie_pkg::F3_SLTU: alu_val = {31'd0, a < op2};
            rv32ie_pkg::F3_XOR:  alu_val = a ^ op2;
            rv32ie_pkg::F3_SR:   alu_val = it.alt ? 32'($signed(a) >>> shamt) : (a >> shamt);
            rv32ie_pkg::F3_OR:   alu_val = a | op2;
            default:             alu_val = a & op2;
        endcase
    end

    always_comb begin
        case (it.funct3)
            rv32ie_pkg::F3_BEQ:  taken = (a == b);
            rv32ie_pkg::F3_BNE:  taken = (a != b);
            rv32ie_pkg::F3_BLT:  taken = $signed(a) < $signed(b);
            rv32ie_pkg::F3_BGE:  taken = !($signed(a) < $signed(b));
            rv32ie_pkg::F3_BLTU: taken = (a < b);
            rv32ie_pkg::F3_BGEU: taken = (a >= b);
            default:             taken = 1'b0;
        endcase
    end

    assign pc_plus4 = pc_reg + 32'd4;
    assign pc_imm   = pc_reg + it.imm;
    assign ea       = a + it.imm;
    assign mem_addr = (it.cls == rv32ie_pkg::CLS_PRELOAD) ?
                      {20'd0, it.preload_address} : ea;
    assign st_data  = (it.cls == rv32ie_pkg::CLS_PRELOAD) ? it.preload_data : b;

    always_comb begin
        if (it.cls == rv32ie_pkg::CLS_PRELOAD || it.funct3[1]) begin
            nbytes = 3'd4;
        end else if (it.funct3[0]) begin
            nbytes = 3'd2;
        end else begin
            nbytes = 3'd1;
        end
    end

    assign lim      = 32'(MEM_BYTES) - {29'd0, nbytes};
    assign in_range = (mem_addr <= lim);
    assign fault    = (it.cls == rv32ie_pkg::CLS_LOAD || it.cls == rv32ie_pkg::CLS_STORE ||
                       it.cls == rv32ie_pkg::CLS_PRELOAD) && !in_range;
    assign mem_we   = st_exec && out_free && in_range &&
                      (it.cls == rv32ie_pkg::CLS_STORE || it.cls == rv32ie_pkg::CLS_PRELOAD);

    always_comb begin
        npc = pc_plus4;
        val = 32'd0;
        case (it.cls)
            rv32ie_pkg::CLS_LUI:     val = it.imm;
            rv32ie_pkg::CLS_AUIPC:   val = pc_imm;
            rv32ie_pkg::CLS_JAL: begin
                val = pc_plus4;
                npc = pc_imm;
            end
            rv32ie_pkg::CLS_JALR: begin
                val = pc_plus4;
                npc = {ea[31:1], 1'b0};
            end
            rv32ie_pkg::CLS_BRANCH: begin
                if (taken) begin
                    npc = pc_imm;
                end
            end
            rv32ie_pkg::CLS_ALUI:    val = alu_val;
            rv32ie_pkg::CLS_ALUR:    val = alu_val;
            rv32ie_pkg::CLS_PRELOAD: npc = pc_reg;
            default: begin
            end
        endcase
    end

    // Byte lanes: lane k holds every byte whose address is k modulo four.
    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [7:0]    lane_mem [ROWS];
        logic [1:0]    off;
        logic          used;
        logic [RW-1:0] row;
        logic [RW-1:0] addr;
        logic [7:0]    wbyte;

        assign off   = 2'(k) - mem_addr[1:0];
        assign used  = ({1'b0, off} < nbytes);
        assign row   = mem_addr[AW-1:2] + RW'(2'(k) < mem_addr[1:0]);
        assign addr  = st_clear ? clr_cnt_reg : row;
        assign wbyte = 8'(st_data >> {off, 3'd0});

        always_ff @(posedge aclk) begin
            if (st_clear) begin
                lane_mem[addr] <= 8'd0;
            end else if (mem_we && used) begin
                lane_mem[addr] <= wbyte;
            end
            if (st_exec && is_load) begin
                bank_q[k] <= lane_mem[addr];
            end
        end
    end

    assign lb0 = bank_q[ld_a0_reg];
    assign lb1 = bank_q[ld_a0_reg + 2'd1];
    assign lb2 = bank_q[ld_a0_reg + 2'd2];
    assign lb3 = bank_q[ld_a0_reg + 2'd3];

    always_comb begin
        case (it.funct3)
            rv32ie_pkg::F3_LB:  ld_val = {{24{lb0[7]}}, lb0};
            rv32ie_pkg::F3_LH:  ld_val = {{16{lb1[7]}}, lb1, lb0};
            rv32ie_pkg::F3_LBU: ld_val = {24'd0, lb0};
            rv32ie_pkg::F3_LHU: ld_val = {16'd0, lb1, lb0};
            default:            ld_val = {lb3, lb2, lb1, lb0};
        endcase
        if (ld_fault_reg) begin
            ld_val = 32'd0;
        end
    end

    always_comb begin
        if (st_mem) begin
            res_next.executed_pc         = ld_pc_reg;
            res_next.next_pc             = ld_pc_reg + 32'd4;
            res_next.write_value         = it.wr ? ld_val : 32'd0;
            res_next.memory_fault        = ld_fault_reg;
            res_next.illegal_instruction = 1'b0;
        end else begin
            res_next.executed_pc = (it.cls == rv32ie_pkg::CLS_PRELOAD) ? 32'd0 : pc_reg;
            res_next.next_pc             = npc;
            res_next.write_value         = it.wr ? val : 32'd0;
            res_next.memory_fault        = fault;
            res_next.illegal_instruction = (it.cls == rv32ie_pkg::CLS_ILLEGAL);
        end
        res_next.write_enable   = it.wr;
        res_next.write_register = it.wr ? it.rd : 5'd0;
    end

    assign rf_we    = finish && it.wr;
    assign rf_wdata = res_next.write_value;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == RW'(ROWS - 1)) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (q_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (is_load) begin
                    state_next = S_MEM;
                end else if (out_free) begin
                    state_next = S_READ;
                end
            end
            S_MEM: begin
                if (out_free) begin
                    state_next = S_READ;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            pc_reg       <= 32'd0;
            rf_valid_reg <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (st_clear) begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
            end
            if (cfg_wr) begin
                pc_reg <= {20'd0, cfg_pc};
            end else if (st_exec && (is_load || out_free)) begin
                pc_reg <= npc;
            end
            if (rf_we) begin
                rf_valid_reg[it.rd] <= 1'b1;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[it.rd] <= rf_wdata;
        end
        rs1_data_reg <= rf_mem[it.rs1];
        rs2_data_reg <= rf_mem[it.rs2];
        rs1_vld_reg  <= rf_valid_reg[it.rs1];
        rs2_vld_reg  <= rf_valid_reg[it.rs2];
        if (st_exec) begin
            ld_pc_reg    <= pc_reg;
            ld_fault_reg <= fault;
            ld_a0_reg    <= mem_addr[1:0];
        end
        if (finish) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- hw/rtl/rv32i_instruction_execute.sv -----
`timescale 1ns / 1ps

// Channel   Handshake            Word
// s_        s_valid / s_ready    operation, instruction, preload address and data
// m_        m_valid / m_ready    pc pair, register write, fault and illegal flags
// cfg_      cfg_valid / cfg_ready  start pc, also loaded into the pc
//
// An instruction passes through a register file read state, then an execute state;
// a load adds a memory state because of the registered data memory read.
// After reset the data memory is zeroed one word per cycle, during which s_ready
// stays low. A two-entry queue and the result register let the input side keep
// accepting, until the queue fills, while a finished word waits on m_ready.

module rv32i_instruction_execute #(
    parameter int MEM_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_instruction,
    input  logic [11:0] s_preload_address,
    input  logic [31:0] s_preload_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_executed_pc,
    output logic [31:0] m_next_pc,
    output logic        m_write_enable,
    output logic [4:0]  m_write_register,
    output logic [31:0] m_write_value,
    output logic        m_memory_fault,
    output logic        m_illegal_instruction
);

    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic                clearing;
    rv32ie_pkg::item_t   push_item;
    rv32ie_pkg::item_t   head_item;
    rv32ie_pkg::result_t result;

    assign cfg_ready = 1'b1;

    rv32ie_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_instruction     (s_instruction),
        .s_preload_address (s_preload_address),
        .s_preload_data    (s_preload_data),
        .clearing          (clearing),
        .q_full            (q_full),
        .push              (push),
        .item              (push_item)
    );

    rv32ie_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    rv32ie_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_pc   (cfg_data),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_result (result)
    );

    assign m_executed_pc         = result.executed_pc;
    assign m_next_pc             = result.next_pc;
    assign m_write_enable        = result.write_enable;
    assign m_write_register      = result.write_register;
    assign m_write_value         = result.write_value;
    assign m_memory_fault        = result.memory_fault;
    assign m_illegal_instruction = result.illegal_instruction;

endmodule
